/* src/getc_pkg.sv */
`timescale 1ns / 1ps

package getc_pkg;

  // Opcodes carried on the input tuser
  typedef enum logic [0:0] {
    OP_QUERY   = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  // Gear reported with each result
  typedef enum logic [1:0] {
    GEAR_SEC     = 2'd0,
    GEAR_QUARTER = 2'd1,
    GEAR_BEYOND  = 2'd2,
    GEAR_BAD     = 2'd3
  } gear_t;

  localparam int unsigned MS_W    = 32;
  localparam int unsigned SECS_W  = 18;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned STAMP_W = 13;
  localparam int unsigned TICK_W  = 14;

  // Tick limits that move the counter to the next gear
  localparam logic [TICK_W-1:0] SEC_TICK_LIMIT     = 14'd8160;
  localparam logic [TICK_W-1:0] QUARTER_TICK_LIMIT = 14'd8190;

  // Seconds already covered when the quarter-minute gear starts
  localparam logic [SECS_W-1:0] QUARTER_BASE_SECS = 18'd8160;
  localparam logic [SECS_W-1:0] UNSUPPORTED_SECS  = 18'd65534;

  // Rounding offset for the restart stamp (half a kibi-millisecond)
  localparam logic [23:0] HALF_KIBI_MS = 24'd512;
  // One full wrap of the 23-bit millisecond window
  localparam logic [23:0] MS_WRAP = 24'h800000;
  localparam logic [23:0] ONE_SEC_MS = 24'd1000;

  // Reciprocals: floor(x/125) = (x*RECIP_125) >> 22 for x < 2^15,
  // floor(d*2048/1875) = (d*RECIP_Q) >> 25 for d < 2^13
  localparam logic [15:0] RECIP_125 = 16'd33555;
  localparam int unsigned RECIP_125_SH = 22;
  localparam logic [25:0] RECIP_Q = 26'd36650388;
  localparam int unsigned RECIP_Q_SH = 25;

  // Gear markers in the time code
  localparam logic [2:0] CODE_TOP_SEC     = 3'b000;
  localparam logic [2:0] CODE_TOP_QUARTER = 3'b001;
  localparam logic [1:0] CODE_TOP_BEYOND  = 2'b01;

  function automatic gear_t gear_of(input logic [CODE_W-1:0] code);
    gear_t g;
    if (code[15:14] != 2'b00) begin
      g = GEAR_BEYOND;
    end else if (code[13]) begin
      g = GEAR_QUARTER;
    end else begin
      g = GEAR_SEC;
    end
    return g;
  endfunction

endpackage

/* src/geared_elapsed_time_counter.sv */
`timescale 1ns / 1ps

// Channel | Ports             | Contents (low bit first)
// --------+-------------------+------------------------------------------
// input   | in_tvalid/tready  | tdata: now_ms[31:0]; tuser: opcode[0]
// result  | out_tvalid/tready | tdata: elapsed_seconds[17:0], gear[19:18]
//
// One item per cycle sustained while the result is not stalled; an accepted
// item waits in the input register, goes through one pass of logic, and is
// then offered from the result register. The time code updates
// as an item moves into the result register, so the next item always sees it.
// Reset clears the time code to gear 0, stamp 0, and empties both registers.
// A stalled result holds while the input register can still take one more item.
module geared_elapsed_time_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // now_ms[31:0]
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // elapsed_seconds[17:0], gear[19:18], zero[23:20]
);
  import getc_pkg::*;

  logic                 in_valid_r;
  op_t                  in_op_r;
  logic [MS_W-1:0]      in_ms_r;
  logic                 out_valid_r;
  logic [SECS_W-1:0]    out_secs_r;
  gear_t                out_gear_r;
  logic [CODE_W-1:0]    tc_r;

  logic                 advance;
  logic [CODE_W-1:0]    tc_nxt;
  logic [SECS_W-1:0]    secs_nxt;

  logic [STAMP_W-1:0]   st;
  logic [STAMP_W-1:0]   d0;
  logic [14:0]          x0;
  logic [30:0]          p0;
  logic [TICK_W-1:0]    ticks0;
  logic [22:0]          sm;
  logic [22:0]          b0;
  logic [23:0]          el0;
  logic [23:0]          t1000;
  logic [23:0]          diff0;
  logic [SECS_W-1:0]    secs0;
  logic [STAMP_W-1:0]   d1;
  logic [38:0]          p1;
  logic [TICK_W-1:0]    ticks1;
  logic [SECS_W-1:0]    secs1;
  logic [23:0]          rst_sum;

  // Move an item forward when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Seconds gear: ticks = d*1024/1000 = d + floor(3d/125)
  assign st     = tc_r[STAMP_W-1:0];
  assign d0     = in_ms_r[22:10] - st;
  assign x0     = {2'b00, d0} + {1'b0, d0, 1'b0};
  assign p0     = 31'(x0 * RECIP_125);
  assign ticks0 = {1'b0, d0} + {6'd0, p0[29:RECIP_125_SH]};

  // Sub-tick correction: elapsed ms in the 23-bit window, full wrap when equal
  assign sm    = in_ms_r[22:0];
  assign b0    = {st, 10'd0};
  assign el0   = (sm == b0) ? MS_WRAP : {1'b0, sm - b0};
  assign t1000 = {ticks0, 10'd0} - {6'd0, ticks0, 4'd0} - {7'd0, ticks0, 3'd0};
  assign diff0 = el0 - t1000;
  assign secs0 = {4'd0, ticks0} + ((diff0 >= ONE_SEC_MS) ? 18'd1 : 18'd0);

  // Quarter-minute gear: ticks = d*16384/15000 = floor(d*2048/1875)
  assign d1     = in_ms_r[26:14] - st;
  assign p1     = 39'(d1 * RECIP_Q);
  assign ticks1 = p1[38:RECIP_Q_SH];
  assign secs1  = QUARTER_BASE_SECS + {ticks1, 4'd0} - {4'd0, ticks1};

  // Rounded kibi-millisecond restart stamp
  assign rst_sum = {1'b0, in_ms_r[22:0]} + HALF_KIBI_MS;

  // Select the answer and the next time code
  always_comb begin
    tc_nxt   = tc_r;
    secs_nxt = UNSUPPORTED_SECS;
    priority if (in_op_r == OP_RESTART) begin
      tc_nxt   = {CODE_TOP_SEC, rst_sum[22:10]};
      secs_nxt = '0;
    end else if (gear_of(tc_r) == GEAR_SEC) begin
      secs_nxt = secs0;
      if (ticks0 > SEC_TICK_LIMIT) begin
        tc_nxt = {CODE_TOP_QUARTER, in_ms_r[26:14]};
      end
    end else if (gear_of(tc_r) == GEAR_QUARTER) begin
      secs_nxt = secs1;
      if (ticks1 > QUARTER_TICK_LIMIT) begin
        tc_nxt = {CODE_TOP_BEYOND, in_ms_r[29:16]};
      end
    end else begin
      secs_nxt = UNSUPPORTED_SECS;
    end
  end

  // Control and time code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tc_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        tc_r        <= tc_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r <= op_t'(in_tuser[0]);
      in_ms_r <= in_tdata;
    end
    if (advance) begin
      out_secs_r <= secs_nxt;
      out_gear_r <= gear_of(tc_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_gear_r, out_secs_r};

`ifndef ASSERT_OFF
  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // A restart always answers zero seconds in the seconds gear
  a_restart_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_op_r == OP_RESTART) |=>
      (out_secs_r == '0 && out_gear_r == GEAR_SEC && tc_r[15:13] == CODE_TOP_SEC))
    else $error("restart result or time code wrong");

  // The time code never reaches its top bit
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    !tc_r[15])
    else $error("time code out of range");

  // The time code holds when no item moves forward
  a_code_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(tc_r))
    else $error("time code changed without an item");
`endif

endmodule
